// ----- design/qsm_pkg.sv -----
package qsm_pkg;

   localparam int QUAT_W  = 16;
   localparam int SCALE_W = 16;
   localparam int POS_W   = 32;
   localparam int ENTRY_W = 32;

   // quaternion products in Q4.28
   localparam int PROD_W  = 2 * QUAT_W;
   // rotation term in Q.28, wide enough for 1 - 2(a+b) and 2(a+b)
   localparam int TERM_W  = PROD_W + 2;
   // term times scale in Q.36
   localparam int SCALED_W  = TERM_W + SCALE_W;
   localparam int OUT_SHIFT = 20;
   localparam int SHIFT_W   = SCALED_W - OUT_SHIFT;

   localparam logic signed [TERM_W-1:0] ONE_Q28 = TERM_W'(1) <<< 28;

   typedef logic signed [QUAT_W-1:0]  quat_type;
   typedef logic signed [SCALE_W-1:0] scale_type;
   typedef logic signed [POS_W-1:0]   pos_type;
   typedef logic signed [ENTRY_W-1:0] entry_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [TERM_W-1:0]  term_type;

   // diagonal term: 1 - 2(a + b)
   function automatic term_type diag_term(prod_type a, prod_type b);
      term_type ea;
      term_type eb;
      ea = TERM_W'(a);
      eb = TERM_W'(b);
      return ONE_Q28 - ((ea + eb) <<< 1);
   endfunction

   // off-diagonal term: 2(a + b) or 2(a - b)
   function automatic term_type off_term(prod_type a, prod_type b, logic sub);
      term_type ea;
      term_type eb;
      ea = TERM_W'(a);
      eb = TERM_W'(b);
      return sub ? ((ea - eb) <<< 1) : ((ea + eb) <<< 1);
   endfunction

endpackage

// ----- design/quaternion_scale_to_matrix.sv -----
// channel  ports                                 dir  word
// req      req_valid req_stall req_rot_* ...     in   quaternion, scale, position
// rsp      rsp_valid rsp_stall rsp_entry_*       out  twelve matrix entries
//
// three register stages: quaternion products, rotation terms, scaled terms
// one word per cycle while rsp_stall is low, rsp_valid rises once an accepted word has passed stages 1, 2 and 3
// synchronous reset clears the stage valid bits only
// a stage holds while the next one is full and stalled, bubbles are filled
module quaternion_scale_to_matrix
   import qsm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  quat_type  req_rot_x,
   input  quat_type  req_rot_y,
   input  quat_type  req_rot_z,
   input  quat_type  req_rot_w,
   input  scale_type req_scale_x,
   input  scale_type req_scale_y,
   input  scale_type req_scale_z,
   input  pos_type   req_pos_x,
   input  pos_type   req_pos_y,
   input  pos_type   req_pos_z,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output entry_type rsp_entry_00,
   output entry_type rsp_entry_01,
   output entry_type rsp_entry_02,
   output entry_type rsp_entry_04,
   output entry_type rsp_entry_05,
   output entry_type rsp_entry_06,
   output entry_type rsp_entry_08,
   output entry_type rsp_entry_09,
   output entry_type rsp_entry_10,
   output entry_type rsp_entry_12,
   output entry_type rsp_entry_13,
   output entry_type rsp_entry_14
);

   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;
   logic ready1, ready2, ready3;

   assign ready3    = !v3_ff || !rsp_stall;
   assign ready2    = !v2_ff || ready3;
   assign ready1    = !v1_ff || ready2;
   assign req_stall = !ready1;

   assign v1_in = ready1 ? req_valid : v1_ff;
   assign v2_in = ready2 ? v1_ff : v2_ff;
   assign v3_in = ready3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // stage 1: quaternion products
   prod_type xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   prod_type xx_in, yy_in, zz_in, xy_in, xz_in, yz_in, wx_in, wy_in, wz_in;
   scale_type sx1_ff, sy1_ff, sz1_ff;
   pos_type   px1_ff, py1_ff, pz1_ff;

   always_comb begin
      xx_in = PROD_W'(req_rot_x) * PROD_W'(req_rot_x);
      yy_in = PROD_W'(req_rot_y) * PROD_W'(req_rot_y);
      zz_in = PROD_W'(req_rot_z) * PROD_W'(req_rot_z);
      xy_in = PROD_W'(req_rot_x) * PROD_W'(req_rot_y);
      xz_in = PROD_W'(req_rot_x) * PROD_W'(req_rot_z);
      yz_in = PROD_W'(req_rot_y) * PROD_W'(req_rot_z);
      wx_in = PROD_W'(req_rot_w) * PROD_W'(req_rot_x);
      wy_in = PROD_W'(req_rot_w) * PROD_W'(req_rot_y);
      wz_in = PROD_W'(req_rot_w) * PROD_W'(req_rot_z);
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         xx_ff  <= xx_in;
         yy_ff  <= yy_in;
         zz_ff  <= zz_in;
         xy_ff  <= xy_in;
         xz_ff  <= xz_in;
         yz_ff  <= yz_in;
         wx_ff  <= wx_in;
         wy_ff  <= wy_in;
         wz_ff  <= wz_in;
         sx1_ff <= req_scale_x;
         sy1_ff <= req_scale_y;
         sz1_ff <= req_scale_z;
         px1_ff <= req_pos_x;
         py1_ff <= req_pos_y;
         pz1_ff <= req_pos_z;
      end
   end

   // stage 2: rotation terms
   term_type t00_ff, t01_ff, t02_ff, t04_ff, t05_ff, t06_ff, t08_ff, t09_ff, t10_ff;
   term_type t00_in, t01_in, t02_in, t04_in, t05_in, t06_in, t08_in, t09_in, t10_in;
   scale_type sx2_ff, sy2_ff, sz2_ff;
   pos_type   px2_ff, py2_ff, pz2_ff;

   always_comb begin
      t00_in = diag_term(yy_ff, zz_ff);
      t01_in = off_term(xy_ff, wz_ff, 1'b1);
      t02_in = off_term(xz_ff, wy_ff, 1'b0);
      t04_in = off_term(xy_ff, wz_ff, 1'b0);
      t05_in = diag_term(xx_ff, zz_ff);
      t06_in = off_term(yz_ff, wx_ff, 1'b1);
      t08_in = off_term(xz_ff, wy_ff, 1'b1);
      t09_in = off_term(yz_ff, wx_ff, 1'b0);
      t10_in = diag_term(xx_ff, yy_ff);
   end

   always_ff @(posedge clock) begin
      if (ready2) begin
         t00_ff <= t00_in;
         t01_ff <= t01_in;
         t02_ff <= t02_in;
         t04_ff <= t04_in;
         t05_ff <= t05_in;
         t06_ff <= t06_in;
         t08_ff <= t08_in;
         t09_ff <= t09_in;
         t10_ff <= t10_in;
         sx2_ff <= sx1_ff;
         sy2_ff <= sy1_ff;
         sz2_ff <= sz1_ff;
         px2_ff <= px1_ff;
         py2_ff <= py1_ff;
         pz2_ff <= pz1_ff;
      end
   end

   // stage 3: scale by column axis, position passes through
   pos_type px3_ff, py3_ff, pz3_ff;

   always_ff @(posedge clock) begin
      if (ready3) begin
         px3_ff <= px2_ff;
         py3_ff <= py2_ff;
         pz3_ff <= pz2_ff;
      end
   end

   qsm_scale_lane u_lane_00 (.clock, .load(ready3), .term(t00_ff), .scale(sx2_ff),
                             .entry(rsp_entry_00));
   qsm_scale_lane u_lane_01 (.clock, .load(ready3), .term(t01_ff), .scale(sy2_ff),
                             .entry(rsp_entry_01));
   qsm_scale_lane u_lane_02 (.clock, .load(ready3), .term(t02_ff), .scale(sz2_ff),
                             .entry(rsp_entry_02));
   qsm_scale_lane u_lane_04 (.clock, .load(ready3), .term(t04_ff), .scale(sx2_ff),
                             .entry(rsp_entry_04));
   qsm_scale_lane u_lane_05 (.clock, .load(ready3), .term(t05_ff), .scale(sy2_ff),
                             .entry(rsp_entry_05));
   qsm_scale_lane u_lane_06 (.clock, .load(ready3), .term(t06_ff), .scale(sz2_ff),
                             .entry(rsp_entry_06));
   qsm_scale_lane u_lane_08 (.clock, .load(ready3), .term(t08_ff), .scale(sx2_ff),
                             .entry(rsp_entry_08));
   qsm_scale_lane u_lane_09 (.clock, .load(ready3), .term(t09_ff), .scale(sy2_ff),
                             .entry(rsp_entry_09));
   qsm_scale_lane u_lane_10 (.clock, .load(ready3), .term(t10_ff), .scale(sz2_ff),
                             .entry(rsp_entry_10));

   assign rsp_valid    = v3_ff;
   assign rsp_entry_12 = px3_ff;
   assign rsp_entry_13 = py3_ff;
   assign rsp_entry_14 = pz3_ff;

   // input stalls only when every stage is full and the output is stalled
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && rsp_stall))
      else $error("req_stall with a free stage");

   // a word in stage 2 moves to the output when it can
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && ready3) |=> v3_ff)
      else $error("word lost between stage 2 and output");

   // position word follows its stage 2 copy
   a_pos_follow: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && ready3) |=> (rsp_entry_12 == $past(px2_ff)))
      else $error("position word out of step");

endmodule

// ----- design/qsm_scale_lane.sv -----
module qsm_scale_lane
   import qsm_pkg::*;
(
   input  logic      clock,
   input  logic      load,
   input  term_type  term,
   input  scale_type scale,
   output entry_type entry
);

   logic signed [SCALED_W-1:0] scaled_ff;
   logic signed [SCALED_W-1:0] scaled_in;
   logic signed [SHIFT_W-1:0]  shifted;
   logic signed [SHIFT_W:0]    top_bits;

   assign scaled_in = SCALED_W'(term) * SCALED_W'(scale);

   always_ff @(posedge clock) begin
      if (load) begin
         scaled_ff <= scaled_in;
      end
   end

   // floor shift to Q16.16, saturate to the entry range when SHIFT_W exceeds ENTRY_W
   assign shifted  = scaled_ff[SCALED_W-1:OUT_SHIFT];
   assign top_bits = (SHIFT_W + 1)'(shifted) >>> (ENTRY_W - 1);

   always_comb begin
      if (SHIFT_W <= ENTRY_W) begin
         entry = ENTRY_W'(shifted);
      end else if (top_bits == '0 || top_bits == '1) begin
         entry = ENTRY_W'(shifted);
      end else if (shifted[SHIFT_W-1]) begin
         entry = {1'b1, {(ENTRY_W-1){1'b0}}};
      end else begin
         entry = {1'b0, {(ENTRY_W-1){1'b1}}};
      end
   end

endmodule
